>>> sv/dfmm_pkg.sv
// shared types, constants and the distance table generator of the depth normaliser
// no dependencies; used by dfmm_front, dfmm_queue, dfmm_back and the top level
package dfmm_pkg;

  localparam int DIST_W      = 24;
  localparam int RAW_IN_W    = 11;
  localparam int GRAY_W      = 8;
  localparam int IN_DATA_W   = 16;
  localparam int IN_USER_W   = 2;
  localparam int OUT_DATA_W  = 8;
  localparam int RAW_BITS    = 11;
  localparam int FRAC_BITS   = 8;
  localparam int QUEUE_DEPTH = 4;

  localparam longint Q30          = 64'sd1 <<< 30;
  localparam longint PI_Q30       = 64'sd3373259426;
  localparam longint DIST_MAX     = 64'sd8388607;
  localparam longint DIST_MIN     = -64'sd8388608;
  localparam int     TAYLOR_TERMS = 13;

  typedef enum logic {
    OP_MEASURE = 1'b0,
    OP_CONVERT = 1'b1
  } op_e;

  // one looked-up pixel on its way from front to back
  typedef struct packed {
    op_e                      op;
    logic                     frame_start;
    logic                     last;
    logic signed [DIST_W-1:0] distance;
  } entry_t;

  // shift-subtract division of magnitudes, elaboration only
  function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], n[i]};
      if (r >= d) begin
        r    = r - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // signed quotient truncated toward zero
  function automatic longint sdiv_tz(longint a, longint b);
    logic [63:0] ma;
    logic [63:0] mb;
    longint      q;
    ma = (a < 0) ? 64'(-a) : 64'(a);
    mb = (b < 0) ? 64'(-b) : 64'(b);
    q  = longint'(udiv64(ma, mb));
    return ((a < 0) != (b < 0)) ? -q : q;
  endfunction

  function automatic logic signed [DIST_W-1:0] sat_dist(longint v);
    longint c;
    c = v;
    if (v > DIST_MAX) c = DIST_MAX;
    if (v < DIST_MIN) c = DIST_MIN;
    return DIST_W'(c);
  endfunction

  // tan(raw/1024 + 0.5) * 33.825 + 5.7 via Q30 Taylor sums
  function automatic logic signed [DIST_W-1:0] dist_of(int unsigned raw, int frac);
    longint s;
    longint sn;
    longint cs;
    longint ts;
    longint tc;
    longint num;
    longint den;
    longint q;
    longint one;
    s = ((longint'(raw) + 64'sd512) <<< 20) % PI_Q30;
    if (s > PI_Q30 / 2) s = s - PI_Q30;
    sn  = 0;
    cs  = 0;
    ts  = s;
    tc  = Q30;
    one = 64'sd1 <<< frac;
    for (int k = 0; k < TAYLOR_TERMS; k++) begin
      sn = sn + ts;
      cs = cs + tc;
      ts = ts * s / Q30;
      ts = ts * s / Q30;
      ts = -sdiv_tz(ts, longint'((2 * k + 2) * (2 * k + 3)));
      tc = tc * s / Q30;
      tc = tc * s / Q30;
      tc = -sdiv_tz(tc, longint'((2 * k + 1) * (2 * k + 2)));
    end
    if (cs == 0) begin
      return (sn > 0) ? sat_dist(DIST_MAX) : sat_dist(DIST_MIN);
    end
    num = sn * 64'sd33825 * one;
    den = cs * 64'sd1000;
    if (den < 0) begin
      den = -den;
      num = -num;
    end
    if (num >= 0) q = sdiv_tz(num + den / 2, den);
    else          q = -sdiv_tz(-num + den / 2, den);
    q = q + (64'sd57 * one + 64'sd5) / 10;
    return sat_dist(q);
  endfunction

  // minimum tracker start value, 10000 cm in table format
  function automatic logic signed [DIST_W-1:0] min_reset(int frac);
    return sat_dist(64'sd10000 * (64'sd1 <<< frac));
  endfunction

endpackage

>>> sv/depth_frame_minmax_normalizer_unit.sv
// top level of the depth frame min/max normaliser
// depends on dfmm_pkg, dfmm_front, dfmm_queue and dfmm_back
//
// the host sends every raw depth frame twice over the slave stream. each raw code goes
// through a read-only distance table (tan(raw/1024 + 0.5) * 33.825 + 5.7 cm, signed, with
// FRAC_BITS fraction bits, saturated to 24 bits). words with op = measure update the
// minimum and maximum distance (frame_start restarts them at 10000 cm and 0 before that
// pixel counts) and give no output word. words with op = convert give one gray word each:
// 255 when the distance is at or below the minimum or the range is empty, otherwise
// floor((dist - min) * 255 / (max - min)) capped at 255; tlast is copied through. the front
// takes one word a cycle while the queue has room and does a registered table read; a short
// queue holds looked-up pixels for the back end, where a measure pixel updates the trackers
// and a convert pixel passes a prepare step, then, unless saturated, the restoring divider
// that makes one quotient bit per cycle, then a done step; no new pixel is taken until idle
// again. the output word sits in a register, so the back end carries on while a result waits
// to be taken. no clearing pass after reset; the table holds its contents from the start.
module depth_frame_minmax_normalizer_unit #(
  parameter int RAW_BITS    = dfmm_pkg::RAW_BITS,
  parameter int FRAC_BITS   = dfmm_pkg::FRAC_BITS,
  parameter int QUEUE_DEPTH = dfmm_pkg::QUEUE_DEPTH
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // slave side: pixel words
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [dfmm_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // raw_depth[10:0], zero pad
  input  logic [dfmm_pkg::IN_USER_W-1:0]     s_axis_tuser,  // op[0], frame_start[1]
  input  logic                               s_axis_tlast,  // last_pixel
  // master side: gray words
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [dfmm_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // gray[7:0]
  output logic                               m_axis_tlast   // last_out
);

  // front to queue
  logic             fq_valid;
  logic             fq_ready;
  dfmm_pkg::entry_t fq_entry;

  // queue to back
  logic             qb_valid;
  logic             qb_ready;
  dfmm_pkg::entry_t qb_entry;

  logic [dfmm_pkg::GRAY_W-1:0] gray;

  // lookup stage, one word a cycle while the queue has room
  dfmm_front #(
    .RAW_BITS  (RAW_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .op_i          (s_axis_tuser[0]),
    .raw_i         (s_axis_tdata[dfmm_pkg::RAW_IN_W-1:0]),
    .frame_start_i (s_axis_tuser[1]),
    .last_i        (s_axis_tlast),
    .push_valid_o  (fq_valid),
    .push_ready_i  (fq_ready),
    .entry_o       (fq_entry)
  );

  // decouples the lookup from the slower divide
  dfmm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_entry_i (fq_entry),
    .pop_valid_o  (qb_valid),
    .pop_ready_i  (qb_ready),
    .pop_entry_o  (qb_entry)
  );

  // trackers, divider and output register
  dfmm_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (qb_valid),
    .pop_ready_o (qb_ready),
    .pop_entry_i (qb_entry),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .gray_o      (gray),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = dfmm_pkg::OUT_DATA_W'(gray);

endmodule

>>> sv/dfmm_front.sv
// front end: takes pixel words and looks up the distance in the read-only table
// depends on dfmm_pkg (entry_t, op_e, dist_of)
module dfmm_front #(
  parameter int RAW_BITS  = dfmm_pkg::RAW_BITS,
  parameter int FRAC_BITS = dfmm_pkg::FRAC_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             op_i,
  input  logic [dfmm_pkg::RAW_IN_W-1:0]    raw_i,
  input  logic                             frame_start_i,
  input  logic                             last_i,
  output logic                             push_valid_o,
  input  logic                             push_ready_i,
  output dfmm_pkg::entry_t                 entry_o
);

  localparam int ADDR_W    = (RAW_BITS < dfmm_pkg::RAW_IN_W) ? RAW_BITS : dfmm_pkg::RAW_IN_W;
  localparam int ROM_DEPTH = 1 << ADDR_W;

  logic signed [dfmm_pkg::DIST_W-1:0] rom_w [ROM_DEPTH];

  for (genvar g = 0; g < ROM_DEPTH; g++) begin : g_rom
    localparam logic signed [dfmm_pkg::DIST_W-1:0] Entry = dfmm_pkg::dist_of(g, FRAC_BITS);
    assign rom_w[g] = Entry;
  end

  logic                               stg_valid_q;
  logic                               in_fire;
  dfmm_pkg::op_e                      op_q;
  logic                               fs_q;
  logic                               last_q;
  logic signed [dfmm_pkg::DIST_W-1:0] dist_q;

  assign in_ready_o   = !stg_valid_q || push_ready_i;
  assign in_fire      = in_valid_i && in_ready_o;
  assign push_valid_o = stg_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else if (in_fire) begin
      stg_valid_q <= 1'b1;
    end else if (push_ready_i) begin
      stg_valid_q <= 1'b0;
    end
  end

  // registered table read, tags travel alongside
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      dist_q <= rom_w[raw_i[ADDR_W-1:0]];
      op_q   <= dfmm_pkg::op_e'(op_i);
      fs_q   <= frame_start_i;
      last_q <= last_i;
    end
  end

  always_comb begin
    entry_o.op          = op_q;
    entry_o.frame_start = fs_q;
    entry_o.last        = last_q;
    entry_o.distance    = dist_q;
  end

endmodule

>>> sv/dfmm_queue.sv
// small first-in first-out queue of looked-up pixels between front and back
// depends on dfmm_pkg (entry_t)
module dfmm_queue #(
  parameter int DEPTH = dfmm_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  dfmm_pkg::entry_t push_entry_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output dfmm_pkg::entry_t pop_entry_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  dfmm_pkg::entry_t mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push;
  logic             pop;

  assign push_ready_o = (cnt_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_entry_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

>>> sv/dfmm_back.sv
// back end: min/max tracking on measure pixels, scaled gray value on convert pixels
// depends on dfmm_pkg (entry_t, op_e, min_reset); restoring divider, one quotient bit a cycle
module dfmm_back #(
  parameter int FRAC_BITS = dfmm_pkg::FRAC_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            pop_valid_i,
  output logic                            pop_ready_o,
  input  dfmm_pkg::entry_t                pop_entry_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [dfmm_pkg::GRAY_W-1:0]     gray_o,
  output logic                            last_o
);

  localparam int DW    = dfmm_pkg::DIST_W;
  localparam int EXT_W = DW + 1;
  localparam int GW    = dfmm_pkg::GRAY_W;
  localparam int REM_W = DW + GW;
  localparam int CNT_W = $clog2(GW);
  localparam logic signed [DW-1:0] MinReset = dfmm_pkg::min_reset(FRAC_BITS);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_PREP = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e                   state_q, state_d;
  logic signed [DW-1:0]     min_q, min_d;
  logic signed [DW-1:0]     max_q, max_d;
  logic [DW-1:0]            diff_q, diff_d;
  logic signed [EXT_W-1:0]  range_q, range_d;
  logic                     le_min_q, le_min_d;
  logic                     last_q, last_d;
  logic [REM_W-1:0]         rem_q, rem_d;
  logic [REM_W-1:0]         dvs_q, dvs_d;
  logic [GW-1:0]            quo_q, quo_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic                     out_valid_q;
  logic [GW-1:0]            out_gray_q;
  logic                     out_last_q;

  logic signed [DW-1:0]     pix_dist;
  logic signed [DW-1:0]     base_min;
  logic signed [DW-1:0]     base_max;
  logic signed [EXT_W-1:0]  diff_ext;
  logic                     sat;
  logic                     ge;
  logic                     out_free;
  logic                     out_load;

  assign pix_dist = pop_entry_i.distance;
  assign out_free = !out_valid_q || out_ready_i;
  assign pop_ready_o = (state_q == ST_IDLE);
  assign ge       = (rem_q >= dvs_q);
  assign diff_ext = EXT_W'(pix_dist) - EXT_W'(min_q);
  assign sat      = le_min_q || range_q[DW] || (range_q == '0)
                    || ({1'b0, diff_q} >= range_q[DW:0]);
  assign base_min = pop_entry_i.frame_start ? MinReset : min_q;
  assign base_max = pop_entry_i.frame_start ? '0 : max_q;

  always_comb begin
    state_d  = state_q;
    min_d    = min_q;
    max_d    = max_q;
    diff_d   = diff_q;
    range_d  = range_q;
    le_min_d = le_min_q;
    last_d   = last_q;
    rem_d    = rem_q;
    dvs_d    = dvs_q;
    quo_d    = quo_q;
    cnt_d    = cnt_q;
    out_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (pop_valid_i) begin
          if (pop_entry_i.op == dfmm_pkg::OP_MEASURE) begin
            min_d = (pix_dist < base_min) ? pix_dist : base_min;
            max_d = (pix_dist > base_max) ? pix_dist : base_max;
          end else begin
            diff_d   = diff_ext[DW-1:0];
            range_d  = EXT_W'(max_q) - EXT_W'(min_q);
            le_min_d = (pix_dist <= min_q);
            last_d   = pop_entry_i.last;
            state_d  = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        rem_d = (REM_W'(diff_q) << GW) - REM_W'(diff_q);
        dvs_d = REM_W'(range_q[DW-1:0]) << (GW - 1);
        cnt_d = '0;
        quo_d = '0;
        if (sat) begin
          quo_d   = '1;
          state_d = ST_DONE;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_d = ge ? rem_q - dvs_q : rem_q;
        quo_d = {quo_q[GW-2:0], ge};
        dvs_d = dvs_q >> 1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(GW - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      min_q       <= MinReset;
      max_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      min_q   <= min_d;
      max_q   <= max_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    diff_q   <= diff_d;
    range_q  <= range_d;
    le_min_q <= le_min_d;
    last_q   <= last_d;
    rem_q    <= rem_d;
    dvs_q    <= dvs_d;
    quo_q    <= quo_d;
    cnt_q    <= cnt_d;
    if (out_load) begin
      out_gray_q <= quo_q;
      out_last_q <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign gray_o      = out_gray_q;
  assign last_o      = out_last_q;

endmodule
